@@ rtl/assert_macros.svh @@
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define RHD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define RHD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rhd_pkg.sv @@
package rhd_pkg;

    localparam int IDX_W        = 10;    // home_index / slot_index width
    localparam int DIST_W       = 10;    // stored probe distance width
    localparam int CFG_W        = 11;    // table_size register width
    localparam int CNT_W        = 11;    // item_count port width
    localparam int DEPTH_DEF    = 1024;
    localparam int KEY_BITS_DEF = 32;
    localparam int VAL_BITS_DEF = 32;

    localparam logic [CFG_W-1:0] TSIZE_RESET = 11'd1024;

    typedef enum logic [8:0] {
        ST_CLEAR  = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_MOD    = 9'b000000100,
        ST_LD_CHK = 9'b000001000,
        ST_P_RD   = 9'b000010000,
        ST_P_CHK  = 9'b000100000,
        ST_S_RD   = 9'b001000000,
        ST_S_CHK  = 9'b010000000,
        ST_DONE   = 9'b100000000
    } state_t;

endpackage

@@ rtl/robin_hood_hash_delete.sv @@
// Channel   Direction  Transfer when       Carries
// s_*       in         s_valid & s_ready  mode, key, home/slot index, entry fields
// m_*       out        m_valid & m_ready  found, removed_value, probe_error, item_count
// cfg_*     in         cfg_wr_en          table_size
//
// One bucket memory (registered read, one read and one write port) holds
// key, value, distance and full bit. A load reads the slot, then writes it. A delete
// probes from the home bucket (a home_index >= table size is first reduced by a
// bit-serial remainder), then shifts back, reading and writing each moved bucket.
// After reset a clearing pass writes every bucket empty with s_ready low.
// Inputs are taken only between items; a stalled result holds the next result
// in the done state until m_ready frees the output register.
`include "assert_macros.svh"

module robin_hood_hash_delete #(
    parameter int TABLE_DEPTH = rhd_pkg::DEPTH_DEF,
    parameter int KEY_BITS    = rhd_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS  = rhd_pkg::VAL_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       cfg_wr_en,
    input  logic [rhd_pkg::CFG_W-1:0]  cfg_wr_data,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_mode,
    input  logic [KEY_BITS-1:0]        s_key,
    input  logic [rhd_pkg::IDX_W-1:0]  s_home_index,
    input  logic [rhd_pkg::IDX_W-1:0]  s_slot_index,
    input  logic [VALUE_BITS-1:0]      s_entry_value,
    input  logic [rhd_pkg::DIST_W-1:0] s_entry_distance,
    input  logic                       s_entry_occupied,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_found,
    output logic [VALUE_BITS-1:0]      m_removed_value,
    output logic                       m_probe_error,
    output logic [rhd_pkg::CNT_W-1:0]  m_item_count
);

    localparam int AW      = $clog2(TABLE_DEPTH);
    localparam int CW      = (AW + 1 > rhd_pkg::CFG_W) ? AW + 1 : rhd_pkg::CFG_W;
    localparam int CW1     = CW + 1;
    localparam int CNTW    = $clog2(TABLE_DEPTH + 1);
    localparam int CNT_OUT = rhd_pkg::CNT_W;
    localparam int DW      = rhd_pkg::DIST_W;
    localparam int MW      = $clog2(rhd_pkg::IDX_W);
    localparam int EW      = KEY_BITS + VALUE_BITS + DW + 1;
    localparam int VAL_LSB = KEY_BITS;
    localparam int DST_LSB = KEY_BITS + VALUE_BITS;
    localparam int FULL_B  = EW - 1;

    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);
    localparam logic [MW-1:0] MOD_LAST  = MW'(rhd_pkg::IDX_W - 1);

    // bucket memory
    logic [EW-1:0] mem [TABLE_DEPTH];
    logic [EW-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [EW-1:0] mem_wd;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    rhd_pkg::state_t state_reg, state_next;

    logic [rhd_pkg::CFG_W-1:0] tsize_reg;
    logic [CNTW-1:0]           count_reg, count_next;
    logic [AW-1:0]             clr_reg, clr_next;
    logic [AW-1:0]             loc_reg, loc_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [CW-1:0]             rem_reg, rem_next;
    logic [MW-1:0]             mod_cnt_reg, mod_cnt_next;
    logic [rhd_pkg::IDX_W-1:0] home_reg, home_next;
    logic [KEY_BITS-1:0]       key_reg, key_next;
    logic [EW-1:0]             ld_entry_reg, ld_entry_next;
    logic                      found_reg, found_next;
    logic                      err_reg, err_next;
    logic [VALUE_BITS-1:0]     removed_reg, removed_next;
    logic                      m_valid_reg, m_valid_next;
    logic                      m_found_reg, m_found_next;
    logic                      m_err_reg, m_err_next;
    logic [VALUE_BITS-1:0]     m_removed_reg, m_removed_next;
    logic [CNTW-1:0]           m_count_reg, m_count_next;

    // decoded read data
    logic                  rd_full;
    logic [DW-1:0]         rd_dist;
    logic [VALUE_BITS-1:0] rd_val;
    logic [KEY_BITS-1:0]   rd_key;
    logic                  ld_occ;

    assign rd_full = rd_data_reg[FULL_B];
    assign rd_dist = rd_data_reg[DST_LSB +: DW];
    assign rd_val  = rd_data_reg[VAL_LSB +: VALUE_BITS];
    assign rd_key  = rd_data_reg[0 +: KEY_BITS];
    assign ld_occ  = ld_entry_reg[FULL_B];

    // buckets in use, clipped to the memory depth
    logic [CW-1:0] tsize_ext;
    logic [CW-1:0] n_cur;
    assign tsize_ext = CW'(tsize_reg);
    assign n_cur     = (tsize_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : tsize_ext;

    // next bucket with wrap at the size in use
    logic [CW-1:0] loc_p1;
    logic [AW-1:0] loc_nx;
    assign loc_p1 = CW'(loc_reg) + CW'(1);
    assign loc_nx = (loc_p1 >= n_cur) ? '0 : AW'(loc_p1);

    // one remainder bit per cycle
    logic [CW1-1:0] rem_shift;
    logic [CW1-1:0] rem_sub;
    assign rem_shift = {rem_reg, home_reg[mod_cnt_reg]};
    assign rem_sub   = (rem_shift >= CW1'(n_cur)) ? rem_shift - CW1'(n_cur) : rem_shift;

    logic slot_in_range;
    assign slot_in_range = (32'(s_slot_index) < 32'(TABLE_DEPTH));

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        clr_next       = clr_reg;
        loc_next       = loc_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        mod_cnt_next   = mod_cnt_reg;
        home_next      = home_reg;
        key_next       = key_reg;
        ld_entry_next  = ld_entry_reg;
        found_next     = found_reg;
        err_next       = err_reg;
        removed_next   = removed_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_found_next   = m_found_reg;
        m_err_next     = m_err_reg;
        m_removed_next = m_removed_reg;
        m_count_next   = m_count_reg;
        mem_we         = 1'b0;
        mem_wa         = loc_reg;
        mem_wd         = '0;
        rd_addr        = loc_reg;
        s_ready        = 1'b0;

        case (state_reg)
            rhd_pkg::ST_CLEAR: begin
                mem_we   = 1'b1;
                mem_wa   = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_ADDR) begin
                    state_next = rhd_pkg::ST_IDLE;
                end
            end
            rhd_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                rd_addr = s_mode ? AW'(s_home_index) : AW'(s_slot_index);
                if (s_valid) begin
                    key_next     = s_key;
                    found_next   = 1'b0;
                    err_next     = 1'b0;
                    removed_next = '0;
                    cnt_next     = '0;
                    if (!s_mode) begin
                        ld_entry_next = {s_entry_occupied, s_entry_distance,
                                         s_entry_value, s_key};
                        loc_next      = AW'(s_slot_index);
                        state_next    = slot_in_range ? rhd_pkg::ST_LD_CHK
                                                      : rhd_pkg::ST_DONE;
                    end else if (n_cur == '0) begin
                        err_next   = 1'b1;
                        state_next = rhd_pkg::ST_DONE;
                    end else if (CW'(s_home_index) < n_cur) begin
                        // read at home was issued this cycle
                        loc_next   = AW'(s_home_index);
                        state_next = rhd_pkg::ST_P_CHK;
                    end else begin
                        home_next    = s_home_index;
                        rem_next     = '0;
                        mod_cnt_next = MOD_LAST;
                        state_next   = rhd_pkg::ST_MOD;
                    end
                end
            end
            rhd_pkg::ST_MOD: begin
                rem_next     = CW'(rem_sub);
                mod_cnt_next = mod_cnt_reg - MW'(1);
                if (mod_cnt_reg == '0) begin
                    loc_next   = AW'(rem_sub);
                    state_next = rhd_pkg::ST_P_RD;
                end
            end
            rhd_pkg::ST_LD_CHK: begin
                mem_we = 1'b1;
                mem_wd = ld_entry_reg;
                if (ld_occ && !rd_full) begin
                    count_next = count_reg + CNTW'(1);
                end else if (!ld_occ && rd_full && count_reg != '0) begin
                    count_next = count_reg - CNTW'(1);
                end
                state_next = rhd_pkg::ST_DONE;
            end
            rhd_pkg::ST_P_RD: begin
                state_next = rhd_pkg::ST_P_CHK;
            end
            rhd_pkg::ST_P_CHK: begin
                if (cnt_reg >= n_cur) begin
                    err_next   = 1'b1;
                    state_next = rhd_pkg::ST_DONE;
                end else if (!rd_full || cnt_reg > CW'(rd_dist)) begin
                    state_next = rhd_pkg::ST_DONE;
                end else if (rd_key == key_reg) begin
                    found_next   = 1'b1;
                    removed_next = rd_val;
                    if (count_reg != '0) begin
                        count_next = count_reg - CNTW'(1);
                    end
                    cnt_next   = '0;
                    state_next = rhd_pkg::ST_S_RD;
                end else begin
                    // advance and read the next bucket right away
                    loc_next = loc_nx;
                    cnt_next = cnt_reg + CW'(1);
                    rd_addr  = loc_nx;
                end
            end
            rhd_pkg::ST_S_RD: begin
                rd_addr    = loc_nx;
                state_next = rhd_pkg::ST_S_CHK;
            end
            rhd_pkg::ST_S_CHK: begin
                mem_we = 1'b1;
                // a one-bucket table reads back the bucket being emptied
                if (!rd_full || rd_dist == '0 || loc_nx == loc_reg) begin
                    mem_wd     = '0;
                    state_next = rhd_pkg::ST_DONE;
                end else begin
                    mem_wd = {1'b1, rd_dist - DW'(1), rd_val, rd_key};
                    if (cnt_reg + CW'(1) >= n_cur) begin
                        state_next = rhd_pkg::ST_DONE;
                    end else begin
                        loc_next   = loc_nx;
                        cnt_next   = cnt_reg + CW'(1);
                        state_next = rhd_pkg::ST_S_RD;
                    end
                end
            end
            rhd_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_found_next   = found_reg;
                    m_err_next     = err_reg;
                    m_removed_next = removed_reg;
                    m_count_next   = count_reg;
                    state_next     = rhd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rhd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rhd_pkg::ST_CLEAR;
            tsize_reg   <= rhd_pkg::TSIZE_RESET;
            count_reg   <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                tsize_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        loc_reg       <= loc_next;
        cnt_reg       <= cnt_next;
        rem_reg       <= rem_next;
        mod_cnt_reg   <= mod_cnt_next;
        home_reg      <= home_next;
        key_reg       <= key_next;
        ld_entry_reg  <= ld_entry_next;
        found_reg     <= found_next;
        err_reg       <= err_next;
        removed_reg   <= removed_next;
        m_found_reg   <= m_found_next;
        m_err_reg     <= m_err_next;
        m_removed_reg <= m_removed_next;
        m_count_reg   <= m_count_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_found         = m_found_reg;
    assign m_probe_error   = m_err_reg;
    assign m_removed_value = m_removed_reg;
    assign m_item_count    = CNT_OUT'(m_count_reg);

    `RHD_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNTW'(TABLE_DEPTH), "item count above table depth")
    `RHD_ASSERT_SAME(a_write_states, aclk, aresetn, mem_we, state_reg == rhd_pkg::ST_CLEAR || state_reg == rhd_pkg::ST_LD_CHK || state_reg == rhd_pkg::ST_S_CHK, "bucket write outside clear, load or shift")
    `RHD_ASSERT_SAME(a_found_no_err, aclk, aresetn, m_valid, !(m_found && m_probe_error), "result both found and probe error")
    `RHD_ASSERT_NEXT(a_load_fill, aclk, aresetn, state_reg == rhd_pkg::ST_LD_CHK && ld_occ && !rd_full, count_reg == $past(count_reg) + CNTW'(1), "filling load did not raise count")

endmodule
